>>> rtl/tagged_free_list_stack_top_macros.svh
// ----------------------------------------------------------------------------
// Tagged free-list stack assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef TAGGED_FREE_LIST_STACK_TOP_MACROS_SVH
`define TAGGED_FREE_LIST_STACK_TOP_MACROS_SVH

// Same-cycle implication.
`define TFLS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TFLS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/tfls_pkg.sv
// ----------------------------------------------------------------------------
// Tagged free-list stack package
// Sizes, operation codes, head/command types and field helpers.
// ----------------------------------------------------------------------------
package tfls_pkg;

  parameter int SLOT_COUNT = 256;
  localparam int IDX_W  = $clog2(SLOT_COUNT);
  localparam int LINK_W = IDX_W + 1;
  localparam int GEN_W  = 32;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  typedef struct packed {
    logic              push;
    logic              pop;
    logic [IDX_W-1:0]  push_index;
    logic [LINK_W-1:0] link;
  } head_cmd_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] index;
    logic [GEN_W-1:0] gen;
  } head_t;

  function automatic logic [7:0] to_field(input logic [IDX_W-1:0] x);
    logic [31:0] w;
    w = 32'(x);
    return w[7:0];
  endfunction

endpackage

>>> rtl/tfls_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module tfls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/tfls_head.sv
// ----------------------------------------------------------------------------
// Stack head register
// Holds the top link and the generation tag; applies push and pop updates.
// ----------------------------------------------------------------------------
module tfls_head (
  input  logic               clk,
  input  logic               rst,
  input  tfls_pkg::head_cmd_t cmd,
  output tfls_pkg::head_t     head
);

  import tfls_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      head.valid <= 1'b0;
      head.index <= '0;
      head.gen   <= '0;
    end else if (cmd.push) begin
      head.valid <= 1'b1;
      head.index <= cmd.push_index;
      head.gen   <= head.gen + GEN_W'(1);
    end else if (cmd.pop) begin
      head.valid <= cmd.link[LINK_W-1];
      head.index <= cmd.link[IDX_W-1:0];
      head.gen   <= head.gen + GEN_W'(1);
    end
  end

endmodule

>>> rtl/tagged_free_list_stack_top.sv
// ----------------------------------------------------------------------------
// Tagged free-list stack
// Free slots kept as a linked list in RAM, head and generation in registers.
//
//   channel | handshake         | payload
//   in      | in_valid/in_ready | mode, slot_index
//   out     | out_valid/out_ready | popped_index, empty_res, generation
//
// Push and pop on an empty stack load the output register directly. Pop on
// a non-empty stack reads the link RAM and enters S_READ, where the read
// data sets the new head and the result. One transaction in flight; input
// is taken when the output register is free or drains in the same cycle.
// Reset clears the head to empty and the tag to zero; link RAM not cleared.
// ----------------------------------------------------------------------------
`include "tagged_free_list_stack_top_macros.svh"

module tagged_free_list_stack_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [7:0]  slot_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  popped_index,
  output logic        empty_res,
  output logic [31:0] generation
);

  import tfls_pkg::*;

  typedef enum logic {S_IDLE, S_READ} state_t;

  state_t            state;
  head_t             head;
  head_cmd_t         cmd;
  logic              accept;
  logic              in_range;
  logic              push_ok;
  logic              rd_en;
  logic              load;
  logic [LINK_W-1:0] rd_link;
  logic [7:0]        res_index;
  logic              res_empty;
  logic [GEN_W-1:0]  res_gen;

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign in_range = 32'(slot_index) < 32'(SLOT_COUNT);
  assign push_ok  = accept && (mode == MODE_PUSH) && in_range;
  assign rd_en    = accept && (mode == MODE_POP) && head.valid;

  always_comb begin
    cmd.push       = push_ok;
    cmd.pop        = (state == S_READ);
    cmd.push_index = IDX_W'(slot_index);
    cmd.link       = rd_link;
  end

  tfls_head u_head (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .head (head)
  );

  tfls_ram #(
    .WIDTH (LINK_W),
    .DEPTH (SLOT_COUNT)
  ) u_link_ram (
    .clk   (clk),
    .we    (push_ok),
    .waddr (IDX_W'(slot_index)),
    .wdata ({head.valid, head.index}),
    .re    (rd_en),
    .raddr (head.index),
    .rdata (rd_link)
  );

  always_comb begin
    load      = 1'b0;
    res_index = 8'd0;
    res_empty = 1'b0;
    res_gen   = head.gen;
    if (state == S_READ) begin
      load      = 1'b1;
      res_index = to_field(head.index);
      res_gen   = head.gen + GEN_W'(1);
    end else if (accept && (mode == MODE_PUSH)) begin
      load = 1'b1;
      if (in_range) begin
        res_gen = head.gen + GEN_W'(1);
      end
    end else if (accept && !head.valid) begin
      load      = 1'b1;
      res_empty = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (rd_en) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (load) begin
        out_valid    <= 1'b1;
        popped_index <= res_index;
        empty_res    <= res_empty;
        generation   <= res_gen;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `TFLS_ASSERT_NOW(a_read_out_free, state == S_READ, !out_valid, "output busy on pop")
  `TFLS_ASSERT_NEXT(a_read_follows, rd_en, state == S_READ, "link read without read state")
  `TFLS_ASSERT_NEXT(a_pop_result, state == S_READ, out_valid && !empty_res, "pop result missing")
  `TFLS_ASSERT_NEXT(a_push, push_ok, head.valid && head.index == $past(cmd.push_index), "push head")

endmodule

>>> sim/tb_tagged_free_list_stack_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tagged free-list stack testbench
// Pushes and pops slots through the valid/ready input channel and checks
// every result against a free-list predictor kept in the bench: popped slot,
// empty flag and generation tag. Covers empty pops, index extremes, long
// random push/pop traffic under several idle and stall mixes, a long
// output hold-off that fills the block, and pushes of slots already listed.
// ----------------------------------------------------------------------------
module tb_tagged_free_list_stack_top;
  import tfls_pkg::*;

  localparam int MAX_CYCLES  = 300000;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_WAIT  = 20;

  typedef struct {
    logic [7:0]  popped_index;
    logic        empty_res;
    logic [31:0] generation;
  } stack_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        mode = MODE_PUSH;
  logic [7:0]  slot_index = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  popped_index;
  logic        empty_res;
  logic [31:0] generation;

  // free-list predictor state
  logic        link_ok [256];
  logic [7:0]  link_to [256];
  logic        head_ok = 1'b0;
  logic [7:0]  head_idx = 8'd0;
  logic [31:0] head_gen = 32'd0;

  // slots currently handed out to the requester (candidates for push)
  logic        slot_held [256];
  int          held_count = 256;

  stack_result_t expected_results[$];
  int          err_count = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          hold_req = 0;
  int          hold_ack = 0;
  int          hold_left = 0;

  tagged_free_list_stack_top DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .slot_index   (slot_index),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .popped_index (popped_index),
    .empty_res    (empty_res),
    .generation   (generation)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("tb_tagged_free_list_stack_top NOT OK");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    stack_result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with no expectation pending");
        err_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (popped_index !== exp_r.popped_index) begin
          $error("popped_index: expected %0d, actual %0d", exp_r.popped_index, popped_index);
          err_count++;
        end
        if (empty_res !== exp_r.empty_res) begin
          $error("empty_res: expected %0d, actual %0d", exp_r.empty_res, empty_res);
          err_count++;
        end
        if (generation !== exp_r.generation) begin
          $error("generation: expected %0d, actual %0d", exp_r.generation, generation);
          err_count++;
        end
      end
    end
  end

  function automatic stack_result_t predict_stack_op(input logic m, input logic [7:0] idx);
    stack_result_t r;
    r.popped_index = 8'd0;
    r.empty_res = 1'b0;
    if (m == MODE_PUSH) begin
      if (int'(idx) < SLOT_COUNT) begin
        link_ok[idx] = head_ok;
        link_to[idx] = head_idx;
        head_ok = 1'b1;
        head_idx = idx;
        head_gen = head_gen + 32'd1;
      end
    end else if (!head_ok) begin
      r.empty_res = 1'b1;
    end else begin
      r.popped_index = head_idx;
      head_ok = link_ok[head_idx];
      head_idx = link_to[head_idx];
      head_gen = head_gen + 32'd1;
    end
    r.generation = head_gen;
    return r;
  endfunction

  task automatic send_op(input logic m, input logic [7:0] idx);
    stack_result_t r;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid   <= 1'b1;
    mode       <= m;
    slot_index <= idx;
    do @(posedge clk); while (!(in_valid && in_ready));
    r = predict_stack_op(m, idx);
    expected_results.push_back(r);
    if (m == MODE_PUSH) begin
      if (slot_held[idx]) held_count--;
      slot_held[idx] = 1'b0;
    end else if (!r.empty_res) begin
      if (!slot_held[r.popped_index]) held_count++;
      slot_held[r.popped_index] = 1'b1;
    end
  endtask

  task automatic test_empty_pop();
    send_op(MODE_POP, 8'h00);
    send_op(MODE_POP, 8'hFF);
  endtask

  task automatic test_push_pop_extremes();
    send_op(MODE_PUSH, 8'h00);
    send_op(MODE_PUSH, 8'hFF);
    send_op(MODE_PUSH, 8'hAA);
    send_op(MODE_PUSH, 8'h55);
    repeat (4) send_op(MODE_POP, 8'hFF);
    send_op(MODE_POP, 8'h00);
  endtask

  task automatic test_random_traffic(input int n, input int idle_pct, input int stall);
    logic       m;
    logic [7:0] idx;
    int         push_bias;
    send_idle_pct = idle_pct;
    stall_pct <= stall;
    for (int i = 0; i < n; i++) begin
      // alternate push-heavy and pop-heavy bursts so depth swings to empty
      push_bias = ((i / 40) % 2 == 0) ? 70 : 30;
      if (held_count > 0 && $urandom_range(99) < push_bias) begin
        m = MODE_PUSH;
        do idx = 8'($urandom_range(255)); while (!slot_held[idx]);
      end else begin
        m = MODE_POP;
        idx = 8'($urandom_range(255));
      end
      send_op(m, idx);
    end
  endtask

  task automatic test_backpressure();
    hold_req <= hold_req + 1;
    test_random_traffic(30, 0, 0);
  endtask

  // a repeated push links the list into a ring, so this runs last
  task automatic test_duplicate_push();
    send_op(MODE_PUSH, 8'h07);
    send_op(MODE_PUSH, 8'h09);
    send_op(MODE_PUSH, 8'h07);
    repeat (4) send_op(MODE_POP, 8'h00);
    send_op(MODE_PUSH, 8'h09);
    repeat (2) send_op(MODE_POP, 8'h00);
  endtask

  initial begin
    for (int i = 0; i < 256; i++) begin
      link_ok[i] = 1'b0;
      link_to[i] = 8'd0;
      slot_held[i] = 1'b1;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_pop();
    test_push_pop_extremes();
    test_random_traffic(170, 0, 0);
    test_random_traffic(170, 75, 0);
    test_random_traffic(170, 0, 75);
    test_random_traffic(170, 25, 25);
    test_backpressure();
    test_duplicate_push();

    in_valid <= 1'b0;
    stall_pct <= 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (err_count == 0) begin
      $display("tb_tagged_free_list_stack_top OK");
    end else begin
      $display("tb_tagged_free_list_stack_top NOT OK");
    end
    $finish;
  end

endmodule
